/* hw/rtl/rsl_pkg.sv */
package rsl_pkg;

	localparam int LED_COUNT  = 4;
	localparam int FIFO_DEPTH = 2;

	localparam int TIME_W   = 32;
	localparam int COLOR_W  = 24;
	localparam int PERIOD_W = 24;
	localparam int DUTY_W   = 5;
	localparam int COEFF_W  = 16;
	localparam int TICK_W   = 8;
	localparam int LEVEL_W  = 16;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ENABLE    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_COEFF     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FLASH_PERIOD     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FLASH_DUTY       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DOWNSAMPLE_TICKS = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ON_COLOR         = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_BIND_COLOR       = 3'd6;

	localparam logic                RST_FILTER_ENABLE    = 1'b1;
	localparam logic [COEFF_W-1:0]  RST_FILTER_COEFF     = 16'd49680;
	localparam logic [PERIOD_W-1:0] RST_FLASH_PERIOD     = 24'd500000;
	localparam logic [DUTY_W-1:0]   RST_FLASH_DUTY       = 5'd8;
	localparam logic [TICK_W-1:0]   RST_DOWNSAMPLE_TICKS = 8'd16;
	localparam logic [COLOR_W-1:0]  RST_ON_COLOR         = 24'hFFFFFF;
	localparam logic [COLOR_W-1:0]  RST_BIND_COLOR       = 24'h800080;

	// packed GRB
	localparam logic [COLOR_W-1:0] COL_RED    = 24'h00FF00;
	localparam logic [COLOR_W-1:0] COL_ORANGE = 24'h20FF00;
	localparam logic [COLOR_W-1:0] COL_GREEN  = 24'h800000;
	localparam logic [COLOR_W-1:0] COL_BLUE   = 24'h000080;
	localparam logic [COLOR_W-1:0] COL_BLACK  = 24'h000000;

	// status class decided at the front
	localparam int CLS_W = 3;
	localparam logic [CLS_W-1:0] CLS_LOWBAT   = 3'd0;
	localparam logic [CLS_W-1:0] CLS_BIND     = 3'd1;
	localparam logic [CLS_W-1:0] CLS_FAILSAFE = 3'd2;
	localparam logic [CLS_W-1:0] CLS_ON       = 3'd3;
	localparam logic [CLS_W-1:0] CLS_BLACK    = 3'd4;

	// divider retires this many quotient bits per cycle
	localparam int DIV_RADIX_BITS = 2;
	localparam int DIV_STEPS      = TIME_W / DIV_RADIX_BITS;
	localparam int DIV_CW         = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [CLS_W-1:0]  cls;
		logic [TIME_W-1:0] time_us;
	} item_t;

	typedef struct packed {
		logic                filter_enable;
		logic [COEFF_W-1:0]  filter_coeff;
		logic [PERIOD_W-1:0] flash_period;
		logic [DUTY_W-1:0]   flash_duty;
		logic [TICK_W-1:0]   downsample_ticks;
		logic [COLOR_W-1:0]  on_color;
		logic [COLOR_W-1:0]  bind_color;
	} cfg_t;

endpackage

/* hw/rtl/rgb_status_led_fader_unit.sv */
// Status colour selector and fader for a chain of RGB LEDs.
// Input queue port: one loop tick per transaction (push while full is low),
// carrying the status flags and time_us. A tick counter thins the ticks out;
// only every (downsample_ticks+1)-th tick makes an update.
// Result queue port: an update gives LED_COUNT transactions of the same
// packed GRB colour, the final one with last_led set. The head result sits
// on led_color/last_led while empty is low and is taken with pop.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
// write only while the unit is idle.
// Flow: ticks that make no update are taken one per cycle while the
// FIFO_DEPTH-entry queue between front and back has room. An update runs
// in the back end through fetch, the 2-bit-per-cycle remainder divider
// (flash colours with a non-zero period only), select, the shared filter
// multiplier over three channels in turn and pack (filter on only), then
// LED_COUNT result transactions; the next fetch waits for the last pop.
// Reset clears the tick counter, the filter levels and the queue, and loads
// the register defaults. While pop stays low the back end holds its result;
// the front keeps accepting ticks until the queue fills, then raises full.
module rgb_status_led_fader_unit #(
	parameter int LED_COUNT  = rsl_pkg::LED_COUNT,
	parameter int FIFO_DEPTH = rsl_pkg::FIFO_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            low_battery,
	input  logic                            bind_mode,
	input  logic                            failsafe_active,
	input  logic                            led_switch,
	input  logic [rsl_pkg::TIME_W-1:0]      time_us,
	output logic                            empty,
	input  logic                            pop,
	output logic [rsl_pkg::COLOR_W-1:0]     led_color,
	output logic                            last_led,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rsl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rsl_pkg::CFG_DATA_W-1:0]  cfg_data
);

	rsl_pkg::cfg_t  cfg_q;
	rsl_pkg::item_t front_item;
	rsl_pkg::item_t back_item;
	logic           front_push;
	logic           q_full;
	logic           q_empty;
	logic           back_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_enable    <= rsl_pkg::RST_FILTER_ENABLE;
			cfg_q.filter_coeff     <= rsl_pkg::RST_FILTER_COEFF;
			cfg_q.flash_period     <= rsl_pkg::RST_FLASH_PERIOD;
			cfg_q.flash_duty       <= rsl_pkg::RST_FLASH_DUTY;
			cfg_q.downsample_ticks <= rsl_pkg::RST_DOWNSAMPLE_TICKS;
			cfg_q.on_color         <= rsl_pkg::RST_ON_COLOR;
			cfg_q.bind_color       <= rsl_pkg::RST_BIND_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rsl_pkg::REG_FILTER_ENABLE:    cfg_q.filter_enable    <= cfg_data[0];
				rsl_pkg::REG_FILTER_COEFF:     cfg_q.filter_coeff     <= cfg_data[15:0];
				rsl_pkg::REG_FLASH_PERIOD:     cfg_q.flash_period     <= cfg_data[23:0];
				rsl_pkg::REG_FLASH_DUTY:       cfg_q.flash_duty       <= cfg_data[4:0];
				rsl_pkg::REG_DOWNSAMPLE_TICKS: cfg_q.downsample_ticks <= cfg_data[7:0];
				rsl_pkg::REG_ON_COLOR:         cfg_q.on_color         <= cfg_data[23:0];
				rsl_pkg::REG_BIND_COLOR:       cfg_q.bind_color       <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	rsl_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.low_battery      (low_battery),
		.bind_mode        (bind_mode),
		.failsafe_active  (failsafe_active),
		.led_switch       (led_switch),
		.time_us          (time_us),
		.downsample_ticks (cfg_q.downsample_ticks),
		.q_full           (q_full),
		.q_push           (front_push),
		.q_item           (front_item)
	);

	rsl_fifo #(
		.WIDTH ($bits(rsl_pkg::item_t)),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_push),
		.wr_data (front_item),
		.full    (q_full),
		.rd_en   (back_pop),
		.rd_data (back_item),
		.empty   (q_empty)
	);

	rsl_back #(
		.LED_COUNT (LED_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_item    (back_item),
		.q_pop     (back_pop),
		.led_color (led_color),
		.last_led  (last_led),
		.empty     (empty),
		.pop       (pop)
	);

	// front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		front_push |-> !q_full)
		else $error("queue written while full");

	// after the final LED's transaction the back end goes back to fetch
	a_last_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && last_led) |=> empty)
		else $error("result still shown after last LED");

	// back end fetches only while no result is pending
	a_fetch_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		back_pop |-> empty)
		else $error("queue read while results pending");

endmodule

/* hw/rtl/rsl_front.sv */
module rsl_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        low_battery,
	input  logic                        bind_mode,
	input  logic                        failsafe_active,
	input  logic                        led_switch,
	input  logic [rsl_pkg::TIME_W-1:0]  time_us,
	input  logic [rsl_pkg::TICK_W-1:0]  downsample_ticks,
	input  logic                        q_full,
	output logic                        q_push,
	output rsl_pkg::item_t              q_item
);

	logic [rsl_pkg::TICK_W-1:0] tick_count_q;
	logic [rsl_pkg::TICK_W:0]   tick_next;
	logic                       accept;
	logic                       update;

	assign full      = q_full;
	assign accept    = push && !q_full;
	assign tick_next = {1'b0, tick_count_q} + {{rsl_pkg::TICK_W{1'b0}}, 1'b1};
	assign update    = tick_next > {1'b0, downsample_ticks};
	assign q_push    = accept && update;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
		end else if (accept) begin
			if (update) begin
				tick_count_q <= '0;
			end else begin
				tick_count_q <= tick_next[rsl_pkg::TICK_W-1:0];
			end
		end
	end

	always_comb begin
		q_item.time_us = time_us;
		if (low_battery) begin
			q_item.cls = rsl_pkg::CLS_LOWBAT;
		end else if (bind_mode) begin
			q_item.cls = rsl_pkg::CLS_BIND;
		end else if (failsafe_active) begin
			q_item.cls = rsl_pkg::CLS_FAILSAFE;
		end else if (led_switch) begin
			q_item.cls = rsl_pkg::CLS_ON;
		end else begin
			q_item.cls = rsl_pkg::CLS_BLACK;
		end
	end

endmodule

/* hw/rtl/rsl_fifo.sv */
module rsl_fifo #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = count_q == (AW+1)'(DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

endmodule

/* hw/rtl/rsl_back.sv */
module rsl_back #(
	parameter int LED_COUNT = rsl_pkg::LED_COUNT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rsl_pkg::cfg_t               cfg,
	input  logic                        q_empty,
	input  rsl_pkg::item_t              q_item,
	output logic                        q_pop,
	output logic [rsl_pkg::COLOR_W-1:0] led_color,
	output logic                        last_led,
	output logic                        empty,
	input  logic                        pop
);

	localparam int LED_CW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int LW     = rsl_pkg::LEVEL_W;
	localparam int PW     = rsl_pkg::PERIOD_W;
	localparam int TW     = rsl_pkg::TIME_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_SEL  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_PACK = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	localparam logic [1:0] CH_G = 2'd0;
	localparam logic [1:0] CH_R = 2'd1;
	localparam logic [1:0] CH_B = 2'd2;

	logic [2:0]                        state_q;
	logic [rsl_pkg::CLS_W-1:0]         cls_q;
	logic [TW-1:0]                     dvd_q;
	logic [PW:0]                       rem_q;
	logic [PW:0]                       thr_q;
	logic                              zero_per_q;
	logic                              time_nz_q;
	logic [rsl_pkg::DIV_CW-1:0]        div_cnt_q;
	logic [rsl_pkg::COLOR_W-1:0]       target_q;
	logic [1:0]                        ch_q;
	logic [LW-1:0]                     mag_q;
	logic                              up_q;
	logic [2*LW:0]                     prod_q;
	logic [LW-1:0]                     green_level_q;
	logic [LW-1:0]                     red_level_q;
	logic [LW-1:0]                     blue_level_q;
	logic [rsl_pkg::COLOR_W-1:0]       color_q;
	logic [LED_CW-1:0]                 led_cnt_q;

	logic [PW:0]                       div_r;
	logic [TW-1:0]                     div_n;
	logic [PW+rsl_pkg::DUTY_W-1:0]     thr_full;
	logic                              flash_hi;
	logic [rsl_pkg::COLOR_W-1:0]       target;
	logic [7:0]                        goal_byte;
	logic [LW-1:0]                     goal;
	logic [LW-1:0]                     cur;
	logic                              up;
	logic [LW-1:0]                     mag;
	logic [LW:0]                       weight;
	logic [2*LW+1:0]                   step_sum;
	logic [LW+1:0]                     step_raw;
	logic [LW-1:0]                     step;
	logic [LW-1:0]                     level_new;

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign empty     = state_q != ST_OUT;
	assign led_color = color_q;
	assign last_led  = led_cnt_q == LED_CW'(LED_COUNT - 1);

	// restoring divider, remainder only
	always_comb begin
		div_r = rem_q;
		div_n = dvd_q;
		for (int i = 0; i < rsl_pkg::DIV_RADIX_BITS; i++) begin
			div_r = {div_r[PW-1:0], div_n[TW-1]};
			div_n = {div_n[TW-2:0], 1'b0};
			if (div_r >= {1'b0, cfg.flash_period}) begin
				div_r = div_r - {1'b0, cfg.flash_period};
			end
		end
	end

	assign thr_full = cfg.flash_period * cfg.flash_duty;
	assign flash_hi = zero_per_q ? time_nz_q : (rem_q > thr_q);

	always_comb begin
		case (cls_q)
			rsl_pkg::CLS_LOWBAT:   target = flash_hi ? rsl_pkg::COL_RED : rsl_pkg::COL_ORANGE;
			rsl_pkg::CLS_BIND:     target = cfg.bind_color;
			rsl_pkg::CLS_FAILSAFE: target = flash_hi ? rsl_pkg::COL_GREEN : rsl_pkg::COL_BLUE;
			rsl_pkg::CLS_ON:       target = cfg.on_color;
			default:               target = rsl_pkg::COL_BLACK;
		endcase
	end

	always_comb begin
		case (ch_q)
			CH_G: begin
				goal_byte = target_q[23:16];
				cur       = green_level_q;
			end
			CH_R: begin
				goal_byte = target_q[15:8];
				cur       = red_level_q;
			end
			default: begin
				goal_byte = target_q[7:0];
				cur       = blue_level_q;
			end
		endcase
	end

	assign goal     = {goal_byte, 8'h00};
	assign up       = goal >= cur;
	assign mag      = up ? (goal - cur) : (cur - goal);
	assign weight   = 17'h10000 - {1'b0, cfg.filter_coeff};
	// round the step away from zero so the level lands on the target
	assign step_sum = {1'b0, prod_q} + (2*LW+2)'(16'hFFFF);
	assign step_raw = step_sum[2*LW+1:LW];
	assign step     = (step_raw > {2'b00, mag_q}) ? mag_q : step_raw[LW-1:0];
	assign level_new = up_q ? (cur + step) : (cur - step);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cls_q      <= q_item.cls;
				dvd_q      <= q_item.time_us;
				rem_q      <= '0;
				thr_q      <= thr_full[PW+rsl_pkg::DUTY_W-1:4];
				zero_per_q <= cfg.flash_period == '0;
				time_nz_q  <= q_item.time_us != '0;
			end
			ST_DIV: begin
				rem_q <= div_r;
				dvd_q <= div_n;
			end
			ST_SEL: begin
				target_q <= target;
				color_q  <= target;
			end
			ST_MUL: begin
				mag_q  <= mag;
				up_q   <= up;
				prod_q <= mag * weight;
			end
			ST_PACK: begin
				color_q <= {green_level_q[LW-1:8], red_level_q[LW-1:8], blue_level_q[LW-1:8]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			div_cnt_q     <= '0;
			ch_q          <= CH_G;
			led_cnt_q     <= '0;
			green_level_q <= '0;
			red_level_q   <= '0;
			blue_level_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					div_cnt_q <= '0;
					if (!q_empty) begin
						if ((q_item.cls == rsl_pkg::CLS_LOWBAT ||
						     q_item.cls == rsl_pkg::CLS_FAILSAFE) &&
						    cfg.flash_period != '0) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_SEL;
						end
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + rsl_pkg::DIV_CW'(1);
					if (div_cnt_q == rsl_pkg::DIV_CW'(rsl_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					ch_q      <= CH_G;
					led_cnt_q <= '0;
					state_q   <= cfg.filter_enable ? ST_MUL : ST_OUT;
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					case (ch_q)
						CH_G:    green_level_q <= level_new;
						CH_R:    red_level_q   <= level_new;
						default: blue_level_q  <= level_new;
					endcase
					if (ch_q == CH_B) begin
						state_q <= ST_PACK;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_PACK: begin
					led_cnt_q <= '0;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (pop) begin
						if (last_led) begin
							state_q <= ST_IDLE;
						end else begin
							led_cnt_q <= led_cnt_q + LED_CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
